>>> rtl/mssb_pkg.sv
// Shared types, constants and register codes for the masked scaled sprite blitter.
package mssb_pkg;

  localparam int MAX_SCALE  = 4;
  localparam int ADDR_W     = 18;
  localparam int CLAMP_W    = $clog2(MAX_SCALE + 1);
  localparam int POS_W      = 8 + CLAMP_W;
  localparam int CRD_W      = POS_W + 3;
  localparam int SUM_W      = 20;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd6;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        pixel_visible;
    logic        first_pixel;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [15:0]       write_color;
    logic              write_last;
  } out_item_t;

  typedef struct packed {
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic [10:0]        tile_width;
    logic [8:0]         tile_height;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic [2:0]         scale_factor;
  } cfg_t;

  // One visible pixel, already clipped to a rectangle of tile coordinates.
  typedef struct packed {
    logic [15:0] color;
    logic        row_major;
    logic [10:0] x_lo;
    logic [10:0] x_hi;
    logic [8:0]  y_lo;
    logic [8:0]  y_hi;
  } job_t;

endpackage

>>> rtl/mssb_front.sv
// Front end: accepts pixels, keeps the source counters and clips each pixel's block.
module mssb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  mssb_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  mssb_pkg::in_item_t in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output mssb_pkg::job_t   job
);
  import mssb_pkg::*;

  logic [7:0]  col_r, row_r, col_nxt, row_nxt;
  logic [7:0]  col_eff, row_eff, col_inc;
  logic        row_ok;
  logic        in_acc;

  logic        a_valid_r;
  logic [7:0]  a_col_r, a_row_r;
  logic [15:0] a_color_r;
  logic        a_active_r;
  logic        a_drain;

  logic [CLAMP_W-1:0]      s;
  logic [POS_W-1:0]        col_prod, row_prod;
  logic signed [CRD_W-1:0] bx, by, tw_s, th_s;
  logic signed [CRD_W-1:0] xv [MAX_SCALE];
  logic signed [CRD_W-1:0] yv [MAX_SCALE];
  logic [MAX_SCALE-1:0]    x_ok, y_ok;
  logic                    job_ok;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    col_eff = in_data.first_pixel ? 8'd0 : col_r;
    row_eff = in_data.first_pixel ? 8'd0 : row_r;
    row_ok  = row_eff < cfg.sprite_height;
    col_inc = col_eff + 8'd1;
    col_nxt = col_eff;
    row_nxt = row_eff;
    // past the sprite the counters hold
    if (row_ok) begin
      if (col_inc >= cfg.sprite_width) begin
        col_nxt = 8'd0;
        row_nxt = row_eff + 8'd1;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= 8'd0;
      row_r     <= 8'd0;
      a_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        a_valid_r <= 1'b1;
      end else if (a_drain) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_col_r    <= col_eff;
      a_row_r    <= row_eff;
      a_color_r  <= in_data.pixel_color;
      a_active_r <= in_data.pixel_visible && row_ok;
    end
  end

  // Clip the scale-by-scale block against the tile.
  always_comb begin
    if (cfg.scale_factor == 3'd0) begin
      s = CLAMP_W'(1);
    end else if (int'(cfg.scale_factor) > MAX_SCALE) begin
      s = CLAMP_W'(MAX_SCALE);
    end else begin
      s = CLAMP_W'(cfg.scale_factor);
    end
    col_prod = POS_W'(a_col_r) * POS_W'(s);
    row_prod = POS_W'(a_row_r) * POS_W'(s);
    bx   = CRD_W'(cfg.origin_x) + $signed(CRD_W'(col_prod));
    by   = CRD_W'(cfg.origin_y) + $signed(CRD_W'(row_prod));
    tw_s = CRD_W'(cfg.tile_width);
    th_s = CRD_W'(cfg.tile_height);
    for (int i = 0; i < MAX_SCALE; i++) begin
      xv[i]   = bx + CRD_W'(i);
      yv[i]   = by + CRD_W'(i);
      x_ok[i] = (CLAMP_W'(i) < s) && !xv[i][CRD_W-1] && (xv[i] < tw_s);
      y_ok[i] = (CLAMP_W'(i) < s) && !yv[i][CRD_W-1] && (yv[i] < th_s);
    end
  end

  always_comb begin
    job.color     = a_color_r;
    job.row_major = (s == CLAMP_W'(2));
    job.x_lo      = 11'd0;
    job.x_hi      = 11'd0;
    job.y_lo      = 9'd0;
    job.y_hi      = 9'd0;
    for (int i = MAX_SCALE - 1; i >= 0; i--) begin
      if (x_ok[i]) job.x_lo = 11'(xv[i]);
      if (y_ok[i]) job.y_lo = 9'(yv[i]);
    end
    for (int i = 0; i < MAX_SCALE; i++) begin
      if (x_ok[i]) job.x_hi = 11'(xv[i]);
      if (y_ok[i]) job.y_hi = 9'(yv[i]);
    end
  end

  assign job_ok    = a_valid_r && a_active_r && (|x_ok) && (|y_ok);
  assign job_valid = job_ok;
  // drop pixels with nothing to draw without waiting on the queue
  assign a_drain   = a_valid_r && (job_ready || !job_ok);
  assign in_ready  = !a_valid_r || a_drain;

endmodule

>>> rtl/mssb_queue.sv
// Small request queue between the front end and the write generator.
module mssb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mssb_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mssb_pkg::job_t pop_data
);
  import mssb_pkg::*;

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               push, pop;

  assign push_ready = count_r != (Q_PTR_W+1)'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop) begin
        count_r <= count_r + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/mssb_back.sv
// Back end: walks clipped blocks; one write per cycle unless stalled.
module mssb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mssb_pkg::cfg_t      cfg,
  input  logic                job_valid,
  output logic                job_ready,
  input  mssb_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_ready,
  output mssb_pkg::out_item_t out_data
);
  import mssb_pkg::*;

  logic        busy_r;
  job_t        job_r;
  logic [10:0] cx_r, cx_nxt;
  logic [8:0]  cy_r, cy_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic             out_free, emit, at_last, load;
  logic [SUM_W-1:0] prod, sum;

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = busy_r && out_free;
  assign at_last   = (cx_r == job_r.x_hi) && (cy_r == job_r.y_hi);
  assign job_ready = !busy_r || (emit && at_last);
  assign load      = job_valid && job_ready;

  assign prod = SUM_W'(cy_r) * SUM_W'(cfg.tile_width);
  assign sum  = prod + SUM_W'(cx_r);

  // scale 2 walks row by row, every other scale column by column
  always_comb begin
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    if (job_r.row_major) begin
      if (cx_r == job_r.x_hi) begin
        cx_nxt = job_r.x_lo;
        cy_nxt = cy_r + 9'd1;
      end else begin
        cx_nxt = cx_r + 11'd1;
      end
    end else begin
      if (cy_r == job_r.y_hi) begin
        cy_nxt = job_r.y_lo;
        cx_nxt = cx_r + 11'd1;
      end else begin
        cy_nxt = cy_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && at_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
      cx_r  <= job.x_lo;
      cy_r  <= job.y_lo;
    end else if (emit) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
    end
    if (emit) begin
      out_data_r.write_address <= ADDR_W'(sum);
      out_data_r.write_color   <= job_r.color;
      out_data_r.write_last    <= at_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/masked_scaled_sprite_blit.sv
// Top level of the masked scaled sprite blitter: configuration registers and wiring.
//
// Pixels arrive in row-major order and are taken at one per cycle by the front end,
// unless it holds a request the queue cannot take; it counts source columns and
// rows and clips each visible pixel's scale-by-scale block to the tile. Pixels that
// are transparent, past the sprite or wholly off the tile do not wait on the queue
// and cause no write. Drawn pixels wait in a four-entry request queue; the write
// generator then issues one write per cycle while the output is not stalled, so a
// pixel with k targets inside the tile gets k writes (up to scale squared, 16 at
// scale 4), and that single write port sets the sustained rate.
// Configuration writes are always taken and must be made while the block is idle.
module masked_scaled_sprite_blit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mssb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mssb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mssb_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mssb_pkg::out_item_t                 out_data
);
  import mssb_pkg::*;

  cfg_t cfg_r;
  job_t f_job, q_job;
  logic f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= 12'sd0;
      cfg_r.origin_y      <= 12'sd0;
      cfg_r.tile_width    <= 11'd320;
      cfg_r.tile_height   <= 9'd30;
      cfg_r.sprite_width  <= 8'd16;
      cfg_r.sprite_height <= 8'd16;
      cfg_r.scale_factor  <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:      cfg_r.origin_x      <= $signed(cfg_data[11:0]);
        REG_ORIGIN_Y:      cfg_r.origin_y      <= $signed(cfg_data[11:0]);
        REG_TILE_WIDTH:    cfg_r.tile_width    <= cfg_data[10:0];
        REG_TILE_HEIGHT:   cfg_r.tile_height   <= cfg_data[8:0];
        REG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_data[7:0];
        REG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_data[7:0];
        REG_SCALE_FACTOR:  cfg_r.scale_factor  <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  mssb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  mssb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  mssb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a queued request always describes a non-empty rectangle
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (q_job.x_lo <= q_job.x_hi) && (q_job.y_lo <= q_job.y_hi))
    else $error("queued request with empty clip rectangle");

  // the front end holds a request the queue could not take
  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !f_ready |=> f_valid && $stable(f_job))
    else $error("front end dropped a stalled request");

  // nothing is issued straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("write issued after reset");
`endif

endmodule
